FILE: design/bpc_pkg.sv
package bpc_pkg;

  localparam int unsigned DEBOUNCE_W = 8;
  localparam int unsigned LONG_W     = 16;
  localparam int unsigned BEEP_W     = 10;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned HELD_W     = 16;
  localparam int unsigned TOTAL_W    = 16;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd60;
  localparam logic [LONG_W-1:0]     LONG_RESET     = 16'd500;
  localparam logic [BEEP_W-1:0]     BEEP_RESET     = 10'd100;

  localparam logic [DEBOUNCE_W-1:0] LOW_RUN_MAX = '1;
  localparam logic [HELD_W-1:0]     HELD_MAX    = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_SHORT_BEEP = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    EV_NONE         = 2'd0,
    EV_LONG_BEGIN   = 2'd1,
    EV_LONG_RELEASE = 2'd2,
    EV_SHORT        = 2'd3
  } event_t;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_ticks;
    logic [LONG_W-1:0]     long_press_ticks;
    logic [BEEP_W-1:0]     short_beep_ticks;
  } cfg_t;

  typedef struct packed {
    logic                buzzer_active;
    event_t              event_code;
    logic [HELD_W-1:0]   held_ticks;
    logic [TOTAL_W-1:0]  short_total;
    logic [TOTAL_W-1:0]  long_total;
  } result_t;

endpackage

FILE: design/bpc_cfg.sv
module bpc_cfg
  import bpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_ticks   <= DEBOUNCE_RESET;
      regs.long_press_ticks <= LONG_RESET;
      regs.short_beep_ticks <= BEEP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEBOUNCE:   regs.debounce_ticks   <= cfg_data[DEBOUNCE_W-1:0];
        REG_LONG_PRESS: regs.long_press_ticks <= cfg_data[LONG_W-1:0];
        REG_SHORT_BEEP: regs.short_beep_ticks <= cfg_data[BEEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

FILE: design/bpc_step.sv
module bpc_step
  import bpc_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  logic    raw_level,
  input  cfg_t    cfg,
  output result_t result
);

  logic [DEBOUNCE_W-1:0]   low_run, low_run_next;
  logic                    debounced, debounced_next;
  logic                    prev_pressed;
  logic                    long_mode, long_mode_next;
  logic [HELD_W-1:0]       press_duration, press_duration_next;
  logic [BEEP_W-1:0]       beep_remaining, beep_remaining_next;
  logic [COUNTER_BITS-1:0] short_counter, short_counter_next;
  logic [COUNTER_BITS-1:0] long_counter, long_counter_next;
  event_t                  ev;
  logic [HELD_W-1:0]       held;

  always_comb begin
    low_run_next        = low_run;
    debounced_next      = debounced;
    long_mode_next      = long_mode;
    press_duration_next = press_duration;
    short_counter_next  = short_counter;
    long_counter_next   = long_counter;
    ev                  = EV_NONE;
    held                = '0;

    // beep counts down before anything else this tick
    beep_remaining_next = (beep_remaining != '0) ? beep_remaining - 1'b1 : beep_remaining;

    if (!raw_level) begin
      if (low_run != LOW_RUN_MAX) low_run_next = low_run + 1'b1;
      if (low_run_next >= cfg.debounce_ticks) debounced_next = 1'b1;
    end else begin
      low_run_next   = '0;
      debounced_next = 1'b0;
    end

    if (debounced_next && !prev_pressed) begin
      press_duration_next = '0;
      long_mode_next      = 1'b0;
    end else if (debounced_next && prev_pressed) begin
      if (press_duration != HELD_MAX) press_duration_next = press_duration + 1'b1;
      if (!long_mode && press_duration_next >= cfg.long_press_ticks) begin
        long_mode_next    = 1'b1;
        long_counter_next = long_counter + 1'b1;
        ev                = EV_LONG_BEGIN;
      end
    end else if (!debounced_next && prev_pressed) begin
      held = press_duration;
      if (long_mode) begin
        ev                  = EV_LONG_RELEASE;
        beep_remaining_next = '0;
      end else begin
        ev                  = EV_SHORT;
        short_counter_next  = short_counter + 1'b1;
        beep_remaining_next = cfg.short_beep_ticks;
      end
      long_mode_next = 1'b0;
    end

    result.buzzer_active = long_mode_next || (beep_remaining_next != '0);
    result.event_code    = ev;
    result.held_ticks    = held;
    result.short_total   = TOTAL_W'(short_counter_next);
    result.long_total    = TOTAL_W'(long_counter_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_run        <= '0;
      debounced      <= 1'b0;
      prev_pressed   <= 1'b0;
      long_mode      <= 1'b0;
      press_duration <= '0;
      beep_remaining <= '0;
      short_counter  <= '0;
      long_counter   <= '0;
    end else if (step) begin
      low_run        <= low_run_next;
      debounced      <= debounced_next;
      prev_pressed   <= debounced_next;
      long_mode      <= long_mode_next;
      press_duration <= press_duration_next;
      beep_remaining <= beep_remaining_next;
      short_counter  <= short_counter_next;
      long_counter   <= long_counter_next;
    end
  end

endmodule

FILE: design/button_press_classifier_top.sv
// Debounced short/long button press classifier. Each input item is one tick
// carrying the raw active-low button level; every item yields exactly one
// result item with the buzzer state, an event code, the held time on release
// and the running short and long press counts. An item is taken every clock
// cycle: the tick's state update is one pass of logic into the result
// register, and a new item is accepted whenever that register is empty or
// being drained in the same cycle. Configuration writes take effect on the
// next clock and are meant for idle periods.
module button_press_classifier_top
  import bpc_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  raw_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  buzzer_active,
  output logic [1:0]            event_code,
  output logic [HELD_W-1:0]     held_ticks,
  output logic [TOTAL_W-1:0]    short_total,
  output logic [TOTAL_W-1:0]    long_total
);

  cfg_t    cfg;
  result_t step_result;
  result_t result;
  logic    accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  bpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpc_step #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .raw_level (raw_level),
    .cfg       (cfg),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= step_result;
    end
  end

  assign buzzer_active = result.buzzer_active;
  assign event_code    = result.event_code;
  assign held_ticks    = result.held_ticks;
  assign short_total   = result.short_total;
  assign long_total    = result.long_total;

endmodule
